/* sv/eolsc_pkg.sv */
// ----------------------------------------------------------------------------
// eolsc_pkg
// Types and constants shared by the end-of-line spacing check block.
// ----------------------------------------------------------------------------
package eolsc_pkg;

  // Rule register width and configuration index width
  localparam int RULE_BITS    = 20;
  localparam int CFG_IDX_BITS = 8;

  // Corner order within a box array
  localparam int BOX_LX = 0;
  localparam int BOX_LY = 1;
  localparam int BOX_HX = 2;
  localparam int BOX_HY = 3;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RULE_PRESENT = 8'd0,
    CFG_EOL_SPACING  = 8'd1,
    CFG_EOL_WIDTH    = 8'd2,
    CFG_EOL_WITHIN   = 8'd3
  } cfg_idx_t;

  // Layer rule as held in the configuration registers
  typedef struct packed {
    logic                 rule_present;
    logic [RULE_BITS-1:0] spacing;
    logic [RULE_BITS-1:0] width;
    logic [RULE_BITS-1:0] widening;
  } eol_rule_t;

endpackage

/* sv/eolsc_eval.sv */
// ----------------------------------------------------------------------------
// eolsc_eval
// Single-pass evaluation: windows, width tests and overlap tests feed the
// result register directly.
// ----------------------------------------------------------------------------
module eolsc_eval #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] a_box [4],
  input  logic signed [COORD_BITS-1:0] b_box [4],
  input  logic                         pin,
  input  eolsc_pkg::eol_rule_t         rule,
  output logic                         out_valid,
  output logic                         out_violation
);
  import eolsc_pkg::*;

  // Internal width: coordinates widened by a rule distance never overflow
  localparam int W = ((COORD_BITS > RULE_BITS) ? COORD_BITS : RULE_BITS + 1) + 2;

  typedef logic signed [W-1:0] crd_t;
  typedef struct packed {
    crd_t lx;
    crd_t ly;
    crd_t hx;
    crd_t hy;
  } box_t;

  // Strictly positive-area intersection, written as eight plain compares
  function automatic logic hits(box_t p, box_t q);
    logic r;
    r = (p.lx < p.hx) && (p.lx < q.hx) && (q.lx < p.hx) && (q.lx < q.hx) &&
        (p.ly < p.hy) && (p.ly < q.hy) && (q.ly < p.hy) && (q.ly < q.hy);
    return r;
  endfunction

  // Widened operands
  box_t a_w, b_w;
  crd_t sp, wd, wi;

  assign a_w = '{lx: W'(a_box[BOX_LX]), ly: W'(a_box[BOX_LY]),
                 hx: W'(a_box[BOX_HX]), hy: W'(a_box[BOX_HY])};
  assign b_w = '{lx: W'(b_box[BOX_LX]), ly: W'(b_box[BOX_LY]),
                 hx: W'(b_box[BOX_HX]), hy: W'(b_box[BOX_HY])};
  assign sp  = W'(rule.spacing);
  assign wd  = W'(rule.width);
  assign wi  = W'(rule.widening);

  // Width tests
  crd_t ext_ax, ext_bx, ext_ay, ext_by;
  logic vchk, hchk;

  assign ext_ax = a_w.hx - a_w.lx;
  assign ext_bx = b_w.hx - b_w.lx;
  assign ext_ay = a_w.hy - a_w.ly;
  assign ext_by = b_w.hy - b_w.ly;

  // rule width above the narrower extent; a pin's own extent never counts
  assign vchk = (wd > ext_ax) || (!pin && (wd > ext_bx));
  assign hchk = (wd > ext_ay) || (!pin && (wd > ext_by));

  // End-of-line windows around A
  box_t win_below, win_above, win_left, win_right;

  assign win_below = '{lx: a_w.lx - wi, ly: a_w.ly - sp, hx: a_w.hx + wi, hy: a_w.ly};
  assign win_above = '{lx: a_w.lx - wi, ly: a_w.hy, hx: a_w.hx + wi, hy: a_w.hy + sp};
  assign win_left  = '{lx: a_w.lx - sp, ly: a_w.ly - wi, hx: a_w.lx, hy: a_w.hy + wi};
  assign win_right = '{lx: a_w.hx, ly: a_w.ly - wi, hx: a_w.hx + sp, hy: a_w.hy + wi};

  // Overlap tests
  logic viol_nxt;
  logic vhit, hhit;

  assign vhit     = hits(win_below, b_w) || hits(win_above, b_w);
  assign hhit     = hits(win_left, b_w) || hits(win_right, b_w);
  assign viol_nxt = rule.rule_present && !hits(a_w, b_w) &&
                    ((vchk && vhit) || (hchk && hhit));

  // Result register
  logic res_vld_r, res_viol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r  <= 1'b0;
      res_viol_r <= 1'b0;
    end else begin
      res_vld_r  <= in_valid;
      res_viol_r <= in_valid && viol_nxt;
    end
  end

  assign out_valid     = res_vld_r;
  assign out_violation = res_viol_r;

endmodule

/* sv/end_of_line_spacing_check.sv */
// ----------------------------------------------------------------------------
// end_of_line_spacing_check
// End-of-line spacing rule check for one layer on a pair of rectangles.
// ----------------------------------------------------------------------------
// One shape pair is taken on every clock cycle in which start is high; busy
// stays low, so pairs may follow back to back. The verdict appears on
// out_violation, flagged by out_valid for one cycle, after the pair has passed
// through the input register and then the result register; the end-of-line
// windows, width tests and overlap compares are formed between the two.
// Results arrive in input order and cannot be held off. Rule registers are
// written through the cfg_ port (always ready) and must only change while no
// pair is in flight.
module end_of_line_spacing_check #(
  parameter int COORD_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input beat
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [COORD_BITS-1:0]            in_a_ll_x,
  input  logic signed [COORD_BITS-1:0]            in_a_ll_y,
  input  logic signed [COORD_BITS-1:0]            in_a_ur_x,
  input  logic signed [COORD_BITS-1:0]            in_a_ur_y,
  input  logic signed [COORD_BITS-1:0]            in_b_ll_x,
  input  logic signed [COORD_BITS-1:0]            in_b_ll_y,
  input  logic signed [COORD_BITS-1:0]            in_b_ur_x,
  input  logic signed [COORD_BITS-1:0]            in_b_ur_y,
  input  logic                                    in_is_pin,
  // result beat
  output logic                                    out_valid,
  output logic                                    out_violation,
  // configuration writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [eolsc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [eolsc_pkg::RULE_BITS-1:0]         cfg_data
);
  import eolsc_pkg::*;

  // Rule registers
  eol_rule_t rule_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RULE_PRESENT: rule_r.rule_present <= cfg_data[0];
        CFG_EOL_SPACING:  rule_r.spacing      <= cfg_data;
        CFG_EOL_WIDTH:    rule_r.width        <= cfg_data;
        CFG_EOL_WITHIN:   rule_r.widening     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  logic                         in_vld_r;
  logic signed [COORD_BITS-1:0] a_r [4];
  logic signed [COORD_BITS-1:0] b_r [4];
  logic                         pin_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
    if (start && !busy) begin
      a_r[BOX_LX] <= in_a_ll_x;
      a_r[BOX_LY] <= in_a_ll_y;
      a_r[BOX_HX] <= in_a_ur_x;
      a_r[BOX_HY] <= in_a_ur_y;
      b_r[BOX_LX] <= in_b_ll_x;
      b_r[BOX_LY] <= in_b_ll_y;
      b_r[BOX_HX] <= in_b_ur_x;
      b_r[BOX_HY] <= in_b_ur_y;
      pin_r       <= in_is_pin;
    end
  end

  // Window evaluation and result register
  eolsc_eval #(
    .COORD_BITS(COORD_BITS)
  ) u_eval (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_vld_r),
    .a_box        (a_r),
    .b_box        (b_r),
    .pin          (pin_r),
    .rule         (rule_r),
    .out_valid    (out_valid),
    .out_violation(out_violation)
  );

endmodule

/* sv/eolsc_checker.sv */
// ----------------------------------------------------------------------------
// eolsc_checker
// Port-level checks on the end-of-line spacing check block, bound to the top.
// ----------------------------------------------------------------------------
module eolsc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_violation,
  input logic cfg_valid,
  input logic cfg_ready
);

  // every accepted beat gives a result once through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted beat produced no result");

  // no result without a matching accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result with no accepted beat");

  // violation flag only alongside the strobe
  a_flag_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !out_violation)
    else $error("violation flag outside a result beat");

  // neither channel ever stalls the sender
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && (!cfg_valid || cfg_ready))
    else $error("block stalled a beat");

endmodule

bind end_of_line_spacing_check eolsc_checker u_eolsc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_violation(out_violation),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);

/* dv/eol_spacing_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eol_spacing_checker
// Watches the input, result and rule write channels of the end-of-line
// spacing check, predicts each verdict and compares it in order.
// ----------------------------------------------------------------------------
module eol_spacing_checker #(
  parameter int COORD_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic                                    busy,
  input  logic signed [COORD_BITS-1:0]            in_a_ll_x,
  input  logic signed [COORD_BITS-1:0]            in_a_ll_y,
  input  logic signed [COORD_BITS-1:0]            in_a_ur_x,
  input  logic signed [COORD_BITS-1:0]            in_a_ur_y,
  input  logic signed [COORD_BITS-1:0]            in_b_ll_x,
  input  logic signed [COORD_BITS-1:0]            in_b_ll_y,
  input  logic signed [COORD_BITS-1:0]            in_b_ur_x,
  input  logic signed [COORD_BITS-1:0]            in_b_ur_y,
  input  logic                                    in_is_pin,
  input  logic                                    out_valid,
  input  logic                                    out_violation,
  input  logic                                    cfg_valid,
  input  logic                                    cfg_ready,
  input  logic [eolsc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [eolsc_pkg::RULE_BITS-1:0]         cfg_data,
  output int                                      errors,
  output int                                      pending,
  output int                                      pairs,
  output int                                      flagged
);
  import eolsc_pkg::*;

  localparam int SHOWN_MAX = 10;

  // Corners widened to 64 bits so window sums never wrap
  typedef struct {
    longint lx;
    longint ly;
    longint hx;
    longint hy;
  } rect_t;

  eol_rule_t rule_q;
  bit        verdict_q[$];
  rect_t     shape_a;
  rect_t     shape_b;
  bit        want;

  function automatic longint lmax(longint x, longint y);
    return (x > y) ? x : y;
  endfunction

  function automatic longint lmin(longint x, longint y);
    return (x < y) ? x : y;
  endfunction

  // Intersection with strictly positive area
  function automatic bit overlaps(rect_t p, rect_t q);
    return (lmax(p.lx, q.lx) < lmin(p.hx, q.hx)) &&
           (lmax(p.ly, q.ly) < lmin(p.hy, q.hy));
  endfunction

  // End-of-line verdict for B as seen from A under the given rule
  function automatic bit eol_violation(eol_rule_t r, rect_t a, rect_t b, bit pin);
    longint sp;
    longint wd;
    longint wi;
    longint ext;
    rect_t  w_lo;
    rect_t  w_hi;
    bit     hit;
    sp  = longint'(r.spacing);
    wd  = longint'(r.width);
    wi  = longint'(r.widening);
    hit = 1'b0;
    if (!r.rule_present || overlaps(a, b)) return 1'b0;
    // vertical: windows below and above A
    ext = a.hx - a.lx;
    if (!pin) ext = lmin(ext, b.hx - b.lx);
    if (wd > ext) begin
      w_lo = '{a.lx - wi, a.ly - sp, a.hx + wi, a.ly};
      w_hi = '{a.lx - wi, a.hy, a.hx + wi, a.hy + sp};
      hit  = overlaps(w_lo, b) || overlaps(w_hi, b);
    end
    // horizontal: windows left and right of A
    if (!hit) begin
      ext = a.hy - a.ly;
      if (!pin) ext = lmin(ext, b.hy - b.ly);
      if (wd > ext) begin
        w_lo = '{a.lx - sp, a.ly - wi, a.lx, a.hy + wi};
        w_hi = '{a.hx, a.ly - wi, a.hx + sp, a.hy + wi};
        hit  = overlaps(w_lo, b) || overlaps(w_hi, b);
      end
    end
    return hit;
  endfunction

  task automatic note_error(string what, logic exp_v, logic got_v);
    errors++;
    if (errors <= SHOWN_MAX)
      $display("%0t: %s: expected violation=%b, got %b", $realtime, what, exp_v, got_v);
  endtask

  initial begin
    errors  = 0;
    pending = 0;
    pairs   = 0;
    flagged = 0;
  end

  // Rule writes, result compare, then prediction for the beat taken this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      rule_q = '0;
      verdict_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RULE_PRESENT: rule_q.rule_present = cfg_data[0];
          CFG_EOL_SPACING:  rule_q.spacing      = cfg_data;
          CFG_EOL_WIDTH:    rule_q.width        = cfg_data;
          CFG_EOL_WITHIN:   rule_q.widening     = cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        if (verdict_q.size() == 0) begin
          note_error("result beat with nothing outstanding", 1'bx, out_violation);
        end else begin
          want = verdict_q.pop_front();
          if (out_violation !== want) note_error("verdict mismatch", want, out_violation);
        end
        if (out_violation === 1'b1) flagged++;
      end
      if (start && !busy) begin
        shape_a = '{longint'(in_a_ll_x), longint'(in_a_ll_y),
                    longint'(in_a_ur_x), longint'(in_a_ur_y)};
        shape_b = '{longint'(in_b_ll_x), longint'(in_b_ll_y),
                    longint'(in_b_ur_x), longint'(in_b_ur_y)};
        verdict_q.push_back(eol_violation(rule_q, shape_a, shape_b, in_is_pin));
        pairs++;
      end
    end
    pending = verdict_q.size();
  end

endmodule

/* dv/end_of_line_spacing_check_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// end_of_line_spacing_check_tb
// Drives shape pairs and rule settings into the end-of-line spacing check;
// a checker beside the block predicts every verdict and counts mismatches.
// ----------------------------------------------------------------------------
module end_of_line_spacing_check_tb;
  import eolsc_pkg::*;

  localparam int CW        = 32;
  localparam int CMAX      = 32'sh7fff_ffff;
  localparam int CMIN      = 32'sh8000_0000;
  localparam int RULE_MAX  = (1 << RULE_BITS) - 1;
  localparam int QUIET_MAX = 4000;
  localparam int BLOCKS    = 15;
  localparam int PER_BLOCK = 100;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [CW-1:0]    in_a_ll_x, in_a_ll_y, in_a_ur_x, in_a_ur_y;
  logic signed [CW-1:0]    in_b_ll_x, in_b_ll_y, in_b_ur_x, in_b_ur_y;
  logic                    in_is_pin;
  logic                    out_valid;
  logic                    out_violation;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [RULE_BITS-1:0]    cfg_data;

  int errors, pending, pairs, flagged;
  int sender_idle;
  int settings;
  int quiet;
  int cur_sp, cur_wd, cur_wi;

  end_of_line_spacing_check #(.COORD_BITS(CW)) dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_a_ll_x(in_a_ll_x), .in_a_ll_y(in_a_ll_y),
    .in_a_ur_x(in_a_ur_x), .in_a_ur_y(in_a_ur_y),
    .in_b_ll_x(in_b_ll_x), .in_b_ll_y(in_b_ll_y),
    .in_b_ur_x(in_b_ur_x), .in_b_ur_y(in_b_ur_y),
    .in_is_pin(in_is_pin),
    .out_valid(out_valid), .out_violation(out_violation),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  eol_spacing_checker #(.COORD_BITS(CW)) u_eol_mon (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_a_ll_x(in_a_ll_x), .in_a_ll_y(in_a_ll_y),
    .in_a_ur_x(in_a_ur_x), .in_a_ur_y(in_a_ur_y),
    .in_b_ll_x(in_b_ll_x), .in_b_ll_y(in_b_ll_y),
    .in_b_ur_x(in_b_ur_x), .in_b_ur_y(in_b_ur_y),
    .in_is_pin(in_is_pin),
    .out_valid(out_valid), .out_violation(out_violation),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .pairs(pairs), .flagged(flagged)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: too long without any beat on any channel
  initial quiet = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("%0t: no beat for %0d cycles", $realtime, QUIET_MAX);
        $display("end_of_line_spacing_check_tb: done, errors");
        $finish;
      end
    end
  end

  // One shape pair beat; start is left high for a possible follow-on beat
  task automatic drive_pair(input int alx, input int aly, input int ahx, input int ahy,
                            input int blx, input int bly, input int bhx, input int bhy,
                            input bit pin);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(negedge clk);
    end
    in_a_ll_x <= alx;
    in_a_ll_y <= aly;
    in_a_ur_x <= ahx;
    in_a_ur_y <= ahy;
    in_b_ll_x <= blx;
    in_b_ll_y <= bly;
    in_b_ur_x <= bhx;
    in_b_ur_y <= bhy;
    in_is_pin <= pin;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and wait until every verdict is back
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [RULE_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Full rule update while idle, plus a write to an unused index
  task automatic program_rule(input bit present, input int sp, input int wd, input int wi);
    settle();
    cfg_write(CFG_RULE_PRESENT, RULE_BITS'(present));
    cfg_write(CFG_EOL_SPACING, RULE_BITS'(sp));
    cfg_write(CFG_EOL_WIDTH, RULE_BITS'(wd));
    cfg_write(CFG_EOL_WITHIN, RULE_BITS'(wi));
    cfg_write(CFG_IDX_BITS'($urandom_range(255, int'(CFG_EOL_WITHIN) + 1)),
              RULE_BITS'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_sp = sp;
    cur_wd = wd;
    cur_wi = wi;
    settings++;
  endtask

  // Mostly B placed around A's end-of-line windows; some raw noise
  task automatic random_pair();
    int kind;
    int bx, by, aw, ah, bw, bh, ox, oy, reach, t;
    kind  = $urandom_range(9);
    reach = cur_sp + cur_wi + 4;
    if (kind == 0) begin
      drive_pair($urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
    end else begin
      bx = int'($urandom) >>> 1;
      by = int'($urandom) >>> 1;
      aw = $urandom_range(2 * cur_wd + 4);
      ah = $urandom_range(2 * cur_wd + 4);
      bw = $urandom_range(2 * cur_wd + 4);
      bh = $urandom_range(2 * cur_wd + 4);
      ox = $urandom_range(aw + 2 * reach + bw);
      ox = ox - reach - bw;
      oy = $urandom_range(ah + 2 * reach + bh);
      oy = oy - reach - bh;
      // butt B against the far end of a window
      if (kind == 2) oy = ah + cur_sp;
      if (kind == 3) ox = -bw - cur_sp;
      if (kind == 4) begin
        // inverted A
        t  = aw;
        aw = -t;
      end
      drive_pair(bx, by, bx + aw, by + ah,
                 bx + ox, by + oy, bx + ox + bw, by + oy + bh, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int sp, wd, wi;
    bit present;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_a_ll_x   = '0;
    in_a_ll_y   = '0;
    in_a_ur_x   = '0;
    in_a_ur_y   = '0;
    in_b_ll_x   = '0;
    in_b_ll_y   = '0;
    in_b_ur_x   = '0;
    in_b_ur_y   = '0;
    in_is_pin   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    sender_idle = 0;
    settings    = 0;
    cur_sp      = 0;
    cur_wd      = 0;
    cur_wi      = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Rule absent after reset: nothing may be flagged
    drive_pair(0, 0, 10, 100, 0, 105, 10, 120, 1'b0);
    drive_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, 1'b1);

    // Directed shapes against a small rule
    program_rule(1'b1, 10, 20, 5);
    drive_pair(0, 0, 10, 100, 0, 105, 10, 120, 1'b0);    // above the line end
    drive_pair(0, 0, 10, 100, 2, -8, 8, -1, 1'b0);       // below
    drive_pair(0, 0, 10, 100, 0, 110, 10, 120, 1'b0);    // just past the spacing
    drive_pair(0, 0, 10, 100, 14, 101, 30, 104, 1'b0);   // inside the sideways widening
    drive_pair(0, 0, 10, 100, 15, 101, 30, 104, 1'b0);   // at the edge of the widening
    drive_pair(0, 0, 10, 100, 5, 50, 40, 60, 1'b0);      // shapes overlap
    drive_pair(0, 0, 10, 100, 10, 0, 20, 100, 1'b0);     // edges touch, zero area
    drive_pair(0, 0, 100, 10, 105, 0, 120, 10, 1'b0);    // right of a horizontal line
    drive_pair(0, 0, 100, 10, -8, 2, -1, 8, 1'b0);       // left
    drive_pair(0, 0, 30, 100, 0, 105, 5, 120, 1'b0);     // narrow target, wide A
    drive_pair(0, 0, 30, 100, 0, 105, 5, 120, 1'b1);     // same, target is a pin
    drive_pair(10, 0, 0, 100, 0, 105, 10, 120, 1'b0);    // inverted A
    drive_pair(0, 0, 10, 100, 10, 120, 0, 105, 1'b0);    // inverted B
    drive_pair(CMIN, CMIN, CMIN + 5, CMIN + 5, CMIN + 2, CMIN + 6, CMIN + 4, CMIN + 9, 1'b0);
    drive_pair(CMAX - 5, CMAX - 20, CMAX, CMAX - 10, CMAX - 4, CMAX - 8, CMAX, CMAX, 1'b0);
    drive_pair(CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, 1'b1);

    // Zero spacing: windows collapse
    program_rule(1'b1, 0, 20, 5);
    drive_pair(0, 0, 10, 100, 0, 100, 10, 120, 1'b0);
    drive_pair(0, 0, 100, 10, 100, 0, 120, 10, 1'b1);

    // Largest rule values near the coordinate limits
    program_rule(1'b1, RULE_MAX, RULE_MAX, RULE_MAX);
    drive_pair(CMAX - 200, CMAX - 300, CMAX - 100, CMAX - 200,
               CMAX - 100, CMAX - 100, CMAX, CMAX, 1'b0);
    drive_pair(CMIN, CMIN, CMIN + 1, CMIN + 1,
               CMIN + 1000000, CMIN, CMIN + 1000010, CMIN + 2, 1'b1);

    // Random blocks, each under a fresh rule
    for (int blk = 0; blk < BLOCKS; blk++) begin
      sender_idle = (blk < 5) ? 16 : (blk < 10) ? 55 : 0;
      present = (blk != 3);
      case (blk % 4)
        0: begin
          sp = $urandom_range(64);
          wd = $urandom_range(64);
          wi = $urandom_range(64);
        end
        1: begin
          sp = $urandom_range(4096);
          wd = $urandom_range(4096);
          wi = $urandom_range(4096);
        end
        2: begin
          sp = $urandom_range(1) ? RULE_MAX : 0;
          wd = $urandom_range(1) ? RULE_MAX : 0;
          wi = $urandom_range(1) ? RULE_MAX : 0;
        end
        default: begin
          sp = $urandom_range(16);
          wd = $urandom_range(RULE_MAX);
          wi = $urandom_range(16);
        end
      endcase
      if (blk == 0) begin
        sp = RULE_MAX;
        wd = RULE_MAX;
        wi = RULE_MAX;
      end
      if (blk == 1) begin
        sp = 0;
        wd = 0;
        wi = 0;
      end
      program_rule(present, sp, wd, wi);
      repeat (PER_BLOCK) random_pair();
    end

    // Drain, then let the pipeline run dry
    settle();
    repeat (8) @(posedge clk);

    $display("end_of_line_spacing_check_tb: %0d shape pairs checked, %0d flagged",
             pairs, flagged);
    $display("end_of_line_spacing_check_tb: %0d rule settings, sender gaps 16%%/55%%/none",
             settings);
    if (pending != 0)
      $display("%0t: %0d verdicts never arrived", $realtime, pending);
    if (errors == 0 && pending == 0) begin
      $display("end_of_line_spacing_check_tb: done, clean");
    end else begin
      $display("end_of_line_spacing_check_tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/eolsc_pkg.sv
sv/eolsc_eval.sv
sv/end_of_line_spacing_check.sv
sv/eolsc_checker.sv
dv/eol_spacing_checker.sv
dv/end_of_line_spacing_check_tb.sv
